[design/pie_pkg.sv]
// ----------------------------------------------------------------------------
// pie_pkg - shared types and constants for the rank iteration engine
// Command and status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package pie_pkg;

  localparam int MAX_NODES_DEF = 4096;
  localparam int MAX_LINKS_DEF = 16384;

  localparam int NODE_CW  = 13;   // node_count register and loop index
  localparam int IDX_W    = 12;   // node index fields
  localparam int ITER_W   = 8;
  localparam int DAMP_W   = 16;
  localparam int DEG_W    = 15;
  localparam int RANK_W   = 32;
  localparam int ACC_W    = 40;
  localparam int LINK_W   = 25;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 16;

  localparam logic [NODE_CW-1:0] NODE_COUNT_RST = 13'd1;
  localparam logic [ITER_W-1:0]  ITER_COUNT_RST = 8'd3;
  localparam logic [DAMP_W-1:0]  DAMP_RST       = 16'd55706;
  localparam logic [DEG_W-1:0]   DEG_MAX        = 15'h7FFF;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_RUN   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_NODE_COUNT = 2'd0,
    REG_ITER_COUNT = 2'd1,
    REG_DAMPING    = 2'd2
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_WR,
    S_RD_OUT,
    S_BASE_DIV,
    S_INIT_DIV,
    S_INIT_WR,
    S_LNK_RD,
    S_LNK_DEC,
    S_LNK_OPS,
    S_LNK_DIV,
    S_LNK_ACC,
    S_NODE_RD,
    S_NODE_MUL,
    S_NODE_WR
  } state_t;

endpackage

[design/pie_ram.sv]
// ----------------------------------------------------------------------------
// pie_ram - generic single-port-write, single-port-read memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/pagerank_iteration_engine_top.sv]
// ----------------------------------------------------------------------------
// pagerank_iteration_engine_top - link store and power-iteration rank engine
// Loads links, keeps degrees per node, runs damped rank iterations and
// answers node reads, all under one sequencer with a shared serial divider.
// ----------------------------------------------------------------------------
//
//   channel  ports                                          direction
//   -------  ---------------------------------------------  ---------
//   in       in_valid/in_stall, cmd, nodes, known, query    into block
//   out      out_valid/out_stall, status, rank, degrees     out of block
//   cfg      cfg_wr_en, cfg_index, cfg_wdata                into block
//
// Add link and read node go through S_ADD_WR and S_RD_OUT; clear sweeps
// all MAX_NODES entries of the degree memories. A run divides out the base
// and initial rank, seeds the nodes, then walks links and nodes per iteration:
// every division goes one quotient bit per cycle through the single serial
// divider; a skipped link does no division.
// After reset the block runs the same degree clear over MAX_NODES entries and
// holds in_stall high meanwhile; configuration writes are taken anyway.
// One command at a time: in_stall stays high while a command is in work
// or its result transfer is still pending on out_stall.
// ----------------------------------------------------------------------------
module pagerank_iteration_engine_top #(
  parameter int MAX_NODES = pie_pkg::MAX_NODES_DEF,
  parameter int MAX_LINKS = pie_pkg::MAX_LINKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [pie_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [pie_pkg::CFG_DW-1:0]  cfg_wdata,
  // command channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_cmd,
  input  logic [pie_pkg::IDX_W-1:0]   in_source_node,
  input  logic                        in_source_known,
  input  logic [pie_pkg::IDX_W-1:0]   in_target_node,
  input  logic [pie_pkg::IDX_W-1:0]   in_query_node,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [pie_pkg::RANK_W-1:0]  out_rank,
  output logic [pie_pkg::DEG_W-1:0]   out_in_degree,
  output logic [pie_pkg::DEG_W-1:0]   out_out_degree
);

  import pie_pkg::*;

  localparam int NAW = $clog2(MAX_NODES);
  localparam int RAW = NAW + 1;               // rank memory: bank bit on top
  localparam int LAW = $clog2(MAX_LINKS);
  localparam int LCW = $clog2(MAX_LINKS + 1);
  localparam logic [LCW-1:0] LINK_FULL = LCW'(MAX_LINKS);
  localparam logic [NAW-1:0] CLR_LAST  = NAW'(MAX_NODES - 1);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t              state_r, state_nxt;
  logic [NODE_CW-1:0]  node_count_r;
  logic [ITER_W-1:0]   iter_count_r;
  logic [DAMP_W-1:0]   damp_r;
  logic [LCW-1:0]      link_total_r, link_total_nxt;
  logic                cur_r, cur_nxt;
  logic [NAW-1:0]      clr_idx_r, clr_idx_nxt;
  logic                clr_emit_r, clr_emit_nxt;
  logic [NODE_CW-1:0]  idx_r, idx_nxt;
  logic [LCW-1:0]      k_r, k_nxt;
  logic [ITER_W-1:0]   it_r, it_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [4:0]          div_cnt_r, div_cnt_nxt;

  // payload
  logic [IDX_W-1:0]    src_r, src_nxt;
  logic [IDX_W-1:0]    tgt_r, tgt_nxt;
  logic                known_r, known_nxt;
  logic [RANK_W-1:0]   base_r, base_nxt;
  logic [RANK_W-1:0]   init_r, init_nxt;
  logic [ACC_W-1:0]    acc_hold_r, acc_hold_nxt;
  logic [ACC_W+DAMP_W-1:0] prod_r, prod_nxt;
  logic [RANK_W-1:0]   div_q_r, div_q_nxt;
  logic [DEG_W:0]      div_rem_r, div_rem_nxt;
  logic [DEG_W-1:0]    div_den_r, div_den_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic [RANK_W-1:0]   out_rank_r, out_rank_nxt;
  logic [DEG_W-1:0]    out_in_deg_r, out_in_deg_nxt;
  logic [DEG_W-1:0]    out_out_deg_r, out_out_deg_nxt;

  // --------------------------------------------------------------------------
  // Memory ports
  // --------------------------------------------------------------------------
  logic              lnk_we;
  logic [LAW-1:0]    lnk_wa, lnk_ra;
  logic [LINK_W-1:0] lnk_wd, lnk_rd;
  logic              ind_we, outd_we;
  logic [NAW-1:0]    ind_wa, ind_ra, outd_wa, outd_ra;
  logic [DEG_W-1:0]  ind_wd, ind_rd, outd_wd, outd_rd;
  logic              rank_we;
  logic [RAW-1:0]    rank_wa, rank_ra;
  logic [RANK_W-1:0] rank_wd, rank_rd;
  logic              acc_we;
  logic [NAW-1:0]    acc_wa, acc_ra;
  logic [ACC_W-1:0]  acc_wd, acc_rd;

  pie_ram #(.WIDTH(LINK_W), .DEPTH(MAX_LINKS)) u_link_ram (
    .clk, .we(lnk_we), .waddr(lnk_wa), .wdata(lnk_wd), .raddr(lnk_ra), .rdata(lnk_rd));
  pie_ram #(.WIDTH(DEG_W), .DEPTH(MAX_NODES)) u_indeg_ram (
    .clk, .we(ind_we), .waddr(ind_wa), .wdata(ind_wd), .raddr(ind_ra), .rdata(ind_rd));
  pie_ram #(.WIDTH(DEG_W), .DEPTH(MAX_NODES)) u_outdeg_ram (
    .clk, .we(outd_we), .waddr(outd_wa), .wdata(outd_wd), .raddr(outd_ra), .rdata(outd_rd));
  pie_ram #(.WIDTH(RANK_W), .DEPTH(2 * MAX_NODES)) u_rank_ram (
    .clk, .we(rank_we), .waddr(rank_wa), .wdata(rank_wd), .raddr(rank_ra), .rdata(rank_rd));
  pie_ram #(.WIDTH(ACC_W), .DEPTH(MAX_NODES)) u_acc_ram (
    .clk, .we(acc_we), .waddr(acc_wa), .wdata(acc_wd), .raddr(acc_ra), .rdata(acc_rd));

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  logic [NODE_CW-1:0] n_eff;
  logic               in_accept;
  logic [DEG_W:0]     div_shift;
  logic               div_ge;
  logic [IDX_W-1:0]   l_src, l_tgt;
  logic               l_known;
  logic [ACC_W+1:0]   acc_sum;
  logic [ACC_W:0]     node_v;
  logic [16:0]        one_minus_d;

  // node_count of zero acts as one; clamp to the memory depth
  always_comb begin
    if (node_count_r == '0) begin
      n_eff = NODE_CW'(1);
    end else if ({19'd0, node_count_r} > 32'(MAX_NODES)) begin
      n_eff = NODE_CW'(MAX_NODES);
    end else begin
      n_eff = node_count_r;
    end
  end

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE) || out_valid_r;

  // restoring divider step: one quotient bit per cycle
  assign div_shift = {div_rem_r[DEG_W-1:0], div_q_r[RANK_W-1]};
  assign div_ge    = div_shift >= {1'b0, div_den_r};

  assign l_src   = lnk_rd[24:13];
  assign l_known = lnk_rd[12];
  assign l_tgt   = lnk_rd[11:0];

  assign acc_sum     = {2'b0, acc_hold_r} + {10'b0, div_q_r};
  assign node_v      = {9'b0, base_r} + {1'b0, prod_r[ACC_W+DAMP_W-1:DAMP_W]};
  assign one_minus_d = 17'h10000 - {1'b0, damp_r};

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    link_total_nxt = link_total_r;
    cur_nxt        = cur_r;
    clr_idx_nxt    = clr_idx_r;
    clr_emit_nxt   = clr_emit_r;
    idx_nxt        = idx_r;
    k_nxt          = k_r;
    it_nxt         = it_r;
    src_nxt        = src_r;
    tgt_nxt        = tgt_r;
    known_nxt      = known_r;
    base_nxt       = base_r;
    init_nxt       = init_r;
    acc_hold_nxt   = acc_hold_r;
    prod_nxt       = prod_r;
    div_q_nxt      = div_q_r;
    div_rem_nxt    = div_rem_r;
    div_den_nxt    = div_den_r;
    div_cnt_nxt    = div_cnt_r;

    // drop the result once its transfer happens
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_rank_nxt    = out_rank_r;
    out_in_deg_nxt  = out_in_deg_r;
    out_out_deg_nxt = out_out_deg_r;

    lnk_we  = 1'b0;
    lnk_wa  = LAW'(link_total_r);
    lnk_wd  = {src_r, known_r, tgt_r};
    lnk_ra  = LAW'(k_r);
    ind_we  = 1'b0;
    ind_wa  = NAW'(tgt_r);
    ind_wd  = '0;
    ind_ra  = NAW'(in_target_node);
    outd_we = 1'b0;
    outd_wa = NAW'(src_r);
    outd_wd = '0;
    outd_ra = NAW'(in_source_node);
    rank_we = 1'b0;
    rank_wa = {cur_r, NAW'(idx_r)};
    rank_wd = init_r;
    rank_ra = {cur_r, NAW'(in_query_node)};
    acc_we  = 1'b0;
    acc_wa  = NAW'(idx_r);
    acc_wd  = '0;
    acc_ra  = NAW'(idx_r);

    // divider advances in every divide state
    if (state_r == S_BASE_DIV || state_r == S_INIT_DIV || state_r == S_LNK_DIV) begin
      div_q_nxt   = {div_q_r[RANK_W-2:0], div_ge};
      div_rem_nxt = div_ge ? (div_shift - {1'b0, div_den_r}) : div_shift;
      div_cnt_nxt = div_cnt_r + 5'd1;
    end

    case (state_r)
      S_CLEAR: begin
        ind_we  = 1'b1;
        ind_wa  = clr_idx_r;
        outd_we = 1'b1;
        outd_wa = clr_idx_r;
        clr_idx_nxt = clr_idx_r + NAW'(1);
        if (clr_idx_r == CLR_LAST) begin
          state_nxt = S_IDLE;
          if (clr_emit_r) begin
            out_valid_nxt   = 1'b1;
            out_status_nxt  = STAT_OK;
            out_rank_nxt    = '0;
            out_in_deg_nxt  = '0;
            out_out_deg_nxt = '0;
          end
        end
      end

      S_IDLE: begin
        if (in_accept) begin
          src_nxt         = in_source_node;
          tgt_nxt         = in_target_node;
          known_nxt       = in_source_known;
          out_status_nxt  = STAT_OK;
          out_rank_nxt    = '0;
          out_in_deg_nxt  = '0;
          out_out_deg_nxt = '0;
          case (in_cmd)
            CMD_CLEAR: begin
              link_total_nxt = '0;
              clr_idx_nxt    = '0;
              clr_emit_nxt   = 1'b1;
              state_nxt      = S_CLEAR;
            end
            CMD_ADD: begin
              if (link_total_r == LINK_FULL) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_FULL;
              end else if ({1'b0, in_target_node} >= n_eff ||
                           (in_source_known && {1'b0, in_source_node} >= n_eff)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_RANGE;
              end else begin
                lnk_we         = 1'b1;
                lnk_wd         = {in_source_node, in_source_known, in_target_node};
                link_total_nxt = link_total_r + LCW'(1);
                state_nxt      = S_ADD_WR;
              end
            end
            CMD_RUN: begin
              div_q_nxt   = {one_minus_d, 15'b0};
              div_rem_nxt = '0;
              div_den_nxt = DEG_W'(n_eff);
              div_cnt_nxt = '0;
              state_nxt   = S_BASE_DIV;
            end
            CMD_READ: begin
              ind_ra  = NAW'(in_query_node);
              outd_ra = NAW'(in_query_node);
              if ({1'b0, in_query_node} >= n_eff) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_RANGE;
              end else begin
                state_nxt = S_RD_OUT;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_ADD_WR: begin
        // bump the in-degree and, for a known source, the out-degree, saturating
        ind_we  = 1'b1;
        ind_wd  = (ind_rd == DEG_MAX) ? ind_rd : ind_rd + DEG_W'(1);
        outd_we = known_r;
        outd_wd = (outd_rd == DEG_MAX) ? outd_rd : outd_rd + DEG_W'(1);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      S_RD_OUT: begin
        out_valid_nxt   = 1'b1;
        out_rank_nxt    = rank_rd;
        out_in_deg_nxt  = ind_rd;
        out_out_deg_nxt = outd_rd;
        state_nxt       = S_IDLE;
      end

      S_BASE_DIV: begin
        if (div_cnt_r == 5'd31) begin
          base_nxt    = {div_q_r[RANK_W-2:0], div_ge};
          div_q_nxt   = 32'h8000_0000;
          div_rem_nxt = '0;
          div_den_nxt = DEG_W'(n_eff);
          div_cnt_nxt = '0;
          state_nxt   = S_INIT_DIV;
        end
      end

      S_INIT_DIV: begin
        if (div_cnt_r == 5'd31) begin
          init_nxt  = {div_q_r[RANK_W-2:0], div_ge};
          idx_nxt   = '0;
          state_nxt = S_INIT_WR;
        end
      end

      S_INIT_WR: begin
        // seed ranks in the current bank and zero the sums
        rank_we = 1'b1;
        acc_we  = 1'b1;
        idx_nxt = idx_r + NODE_CW'(1);
        if (idx_r == n_eff - NODE_CW'(1)) begin
          it_nxt = '0;
          k_nxt  = '0;
          if (iter_count_r == '0) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_LNK_RD;
          end
        end
      end

      S_LNK_RD: begin
        if (k_r == link_total_r) begin
          idx_nxt   = '0;
          state_nxt = S_NODE_RD;
        end else begin
          state_nxt = S_LNK_DEC;
        end
      end

      S_LNK_DEC: begin
        src_nxt = l_src;
        tgt_nxt = l_tgt;
        outd_ra = NAW'(l_src);
        rank_ra = {cur_r, NAW'(l_src)};
        acc_ra  = NAW'(l_tgt);
        if (!l_known || {1'b0, l_src} >= n_eff || {1'b0, l_tgt} >= n_eff) begin
          k_nxt     = k_r + LCW'(1);
          state_nxt = S_LNK_RD;
        end else begin
          state_nxt = S_LNK_OPS;
        end
      end

      S_LNK_OPS: begin
        acc_hold_nxt = acc_rd;
        div_q_nxt    = rank_rd;
        div_rem_nxt  = '0;
        div_den_nxt  = outd_rd;
        div_cnt_nxt  = '0;
        if (outd_rd == '0) begin
          k_nxt     = k_r + LCW'(1);
          state_nxt = S_LNK_RD;
        end else begin
          state_nxt = S_LNK_DIV;
        end
      end

      S_LNK_DIV: begin
        if (div_cnt_r == 5'd31) begin
          state_nxt = S_LNK_ACC;
        end
      end

      S_LNK_ACC: begin
        acc_we    = 1'b1;
        acc_wa    = NAW'(tgt_r);
        acc_wd    = (acc_sum[ACC_W+1:ACC_W] != 2'b0) ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
        k_nxt     = k_r + LCW'(1);
        state_nxt = S_LNK_RD;
      end

      S_NODE_RD: begin
        state_nxt = S_NODE_MUL;
      end

      S_NODE_MUL: begin
        prod_nxt  = acc_rd * damp_r;
        state_nxt = S_NODE_WR;
      end

      S_NODE_WR: begin
        // new rank into the other bank, clear the sum for the next pass
        rank_we = 1'b1;
        rank_wa = {~cur_r, NAW'(idx_r)};
        rank_wd = (node_v[ACC_W:RANK_W] != '0) ? {RANK_W{1'b1}} : node_v[RANK_W-1:0];
        acc_we  = 1'b1;
        idx_nxt = idx_r + NODE_CW'(1);
        state_nxt = S_NODE_RD;
        if (idx_r == n_eff - NODE_CW'(1)) begin
          cur_nxt = ~cur_r;
          it_nxt  = it_r + ITER_W'(1);
          k_nxt   = '0;
          if (it_r + ITER_W'(1) == iter_count_r) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_LNK_RD;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      node_count_r <= NODE_COUNT_RST;
      iter_count_r <= ITER_COUNT_RST;
      damp_r       <= DAMP_RST;
      link_total_r <= '0;
      cur_r        <= 1'b0;
      clr_idx_r    <= '0;
      clr_emit_r   <= 1'b0;
      idx_r        <= '0;
      k_r          <= '0;
      it_r         <= '0;
      out_valid_r  <= 1'b0;
      div_cnt_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      link_total_r <= link_total_nxt;
      cur_r        <= cur_nxt;
      clr_idx_r    <= clr_idx_nxt;
      clr_emit_r   <= clr_emit_nxt;
      idx_r        <= idx_nxt;
      k_r          <= k_nxt;
      it_r         <= it_nxt;
      out_valid_r  <= out_valid_nxt;
      div_cnt_r    <= div_cnt_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_NODE_COUNT: node_count_r <= cfg_wdata[NODE_CW-1:0];
          REG_ITER_COUNT: iter_count_r <= cfg_wdata[ITER_W-1:0];
          REG_DAMPING:    damp_r       <= cfg_wdata;
          default:        ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    src_r         <= src_nxt;
    tgt_r         <= tgt_nxt;
    known_r       <= known_nxt;
    base_r        <= base_nxt;
    init_r        <= init_nxt;
    acc_hold_r    <= acc_hold_nxt;
    prod_r        <= prod_nxt;
    div_q_r       <= div_q_nxt;
    div_rem_r     <= div_rem_nxt;
    div_den_r     <= div_den_nxt;
    out_status_r  <= out_status_nxt;
    out_rank_r    <= out_rank_nxt;
    out_in_deg_r  <= out_in_deg_nxt;
    out_out_deg_r <= out_out_deg_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_rank       = out_rank_r;
  assign out_in_degree  = out_in_deg_r;
  assign out_out_degree = out_out_deg_r;

endmodule

[dv/tb_pagerank_iteration_engine_top.sv]
// ----------------------------------------------------------------------------
// tb_pagerank_iteration_engine_top - self-checking bench for the rank engine
// Drives link loads, runs, reads and clears under random idle gaps and
// backpressure, predicts every result from an internal model of the link
// store, degree tables and rank banks, and checks each result transfer.
// ----------------------------------------------------------------------------
module tb_pagerank_iteration_engine_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pie_pkg::*;

  localparam int NODES = MAX_NODES_DEF;
  localparam int LINKS = MAX_LINKS_DEF;

  typedef struct {
    status_t               status;
    logic [RANK_W-1:0]     rank;
    logic [DEG_W-1:0]      in_deg;
    logic [DEG_W-1:0]      out_deg;
  } node_report_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [CFG_IW-1:0]   cfg_index;
  logic [CFG_DW-1:0]   cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          in_cmd;
  logic [IDX_W-1:0]    in_source_node;
  logic                in_source_known;
  logic [IDX_W-1:0]    in_target_node;
  logic [IDX_W-1:0]    in_query_node;
  logic                out_valid;
  logic                out_stall;
  logic [1:0]          out_status;
  logic [RANK_W-1:0]   out_rank;
  logic [DEG_W-1:0]    out_in_degree;
  logic [DEG_W-1:0]    out_out_degree;

  pagerank_iteration_engine_top u_top (.*);

  // Shadow copy of the engine state
  logic [NODE_CW-1:0]  node_cnt;
  logic [ITER_W-1:0]   iter_cnt;
  logic [DAMP_W-1:0]   damping;
  logic [LINK_W-1:0]   link_mem [LINKS];
  int unsigned         link_cnt;
  int unsigned         in_deg_tbl [NODES];
  int unsigned         out_deg_tbl [NODES];
  logic [RANK_W-1:0]   rank_bank [2][NODES];
  bit                  cur_bank;
  int unsigned         ranked_nodes;   // nodes below this hold a rank from the last run
  logic [63:0]         acc [NODES];

  node_report_t        pending_reports[$];
  int unsigned         mismatches;
  int unsigned         hold_cycles;
  bit                  stall_enable;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #500ms;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned active_nodes();
    if (node_cnt == 0) return 1;
    if (node_cnt > NODES) return NODES;
    return node_cnt;
  endfunction

  // Power iteration with truncating fixed-point steps, as the engine does it
  function automatic void compute_ranks();
    int unsigned n;
    logic [63:0] base;
    logic [63:0] v;
    int unsigned s;
    int unsigned t;
    n = active_nodes();
    base = ((64'd65536 - 64'(damping)) << 15) / n;
    for (int i = 0; i < n; i++) rank_bank[cur_bank][i] = 32'((64'd1 << 31) / n);
    for (int it = 0; it < iter_cnt; it++) begin
      for (int i = 0; i < n; i++) acc[i] = 64'd0;
      for (int k = 0; k < link_cnt; k++) begin
        s = link_mem[k][24:13];
        t = link_mem[k][11:0];
        if (!link_mem[k][12] || s >= n || t >= n || out_deg_tbl[s] == 0) continue;
        acc[t] += 64'(rank_bank[cur_bank][s]) / out_deg_tbl[s];
        if (acc[t] > 64'hFF_FFFF_FFFF) acc[t] = 64'hFF_FFFF_FFFF;
      end
      for (int i = 0; i < n; i++) begin
        v = base + ((acc[i] * damping) >> 16);
        rank_bank[!cur_bank][i] = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
      end
      cur_bank = !cur_bank;
    end
    ranked_nodes = n;
  endfunction

  // Apply one accepted command to the shadow state and queue its report
  function automatic void predict_command(cmd_t cmd, int unsigned src, bit known,
                                          int unsigned dst, int unsigned qry);
    node_report_t r;
    int unsigned n;
    n = active_nodes();
    r = '{STAT_OK, '0, '0, '0};
    case (cmd)
      CMD_CLEAR: begin
        link_cnt = 0;
        for (int i = 0; i < NODES; i++) begin
          in_deg_tbl[i] = 0;
          out_deg_tbl[i] = 0;
        end
      end
      CMD_ADD: begin
        if (link_cnt >= LINKS) r.status = STAT_FULL;
        else if (dst >= n || (known && src >= n)) r.status = STAT_RANGE;
        else begin
          link_mem[link_cnt] = {IDX_W'(src), known, IDX_W'(dst)};
          link_cnt++;
          if (in_deg_tbl[dst] < DEG_MAX) in_deg_tbl[dst]++;
          if (known && out_deg_tbl[src] < DEG_MAX) out_deg_tbl[src]++;
        end
      end
      CMD_RUN: compute_ranks();
      default: begin
        if (qry >= n) r.status = STAT_RANGE;
        else begin
          r.rank = rank_bank[cur_bank][qry];
          r.in_deg = DEG_W'(in_deg_tbl[qry]);
          r.out_deg = DEG_W'(out_deg_tbl[qry]);
        end
      end
    endcase
    pending_reports.push_back(r);
  endfunction

  function automatic int unsigned idle_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Send one command; return once it transfers, with the payload held meanwhile
  task automatic send_command(cmd_t cmd, int unsigned src = 0, bit known = 1'b0,
                              int unsigned dst = 0, int unsigned qry = 0,
                              bit with_gaps = 1'b1);
    int unsigned gap;
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_source_node  <= IDX_W'(src);
    in_source_known <= known;
    in_target_node  <= IDX_W'(dst);
    in_query_node   <= IDX_W'(qry);
    do @(posedge clk); while (in_stall);
    predict_command(cmd, src, known, dst, qry);
    gap = with_gaps ? idle_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every report is in, then let the engine settle
  task automatic drain_reports();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int unsigned value);
    drain_reports();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DW'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_NODE_COUNT: node_cnt = NODE_CW'(value);
      REG_ITER_COUNT: iter_cnt = ITER_W'(value);
      default:        damping  = DAMP_W'(value);
    endcase
  endtask

  // Result side: check each transfer, then pick the stall for the next cycle
  initial begin
    node_report_t want;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer, status %0d", out_status);
        end else begin
          want = pending_reports.pop_front();
          if (out_status !== want.status || out_rank !== want.rank ||
              out_in_degree !== want.in_deg || out_out_degree !== want.out_deg) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st=%0d rank=%h in=%0d out=%0d, got st=%0d rank=%h in=%0d out=%0d",
                       want.status, want.rank, want.in_deg, want.out_deg,
                       out_status, out_rank, out_in_degree, out_out_degree);
          end
        end
      end
      // now and then hold off for a longer stretch
      if (hold_cycles == 0 && stall_enable && $urandom_range(199) == 0)
        hold_cycles = $urandom_range(30, 8);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (stall_enable && $urandom_range(99) < 25)
        out_stall <= 1'b1;
      else
        out_stall <= 1'b0;
    end
  end

  // Pick a read target that never touches a rank left unwritten
  function automatic int unsigned pick_query();
    int unsigned n;
    int unsigned lim;
    n = active_nodes();
    lim = (ranked_nodes < n) ? ranked_nodes : n;
    if (lim > 0 && $urandom_range(9) < 8) return $urandom_range(lim - 1);
    if (n >= NODES) return $urandom_range(NODES - 1) % ((lim > 0) ? lim : 1);
    return $urandom_range(4095, n);
  endfunction

  task automatic test_defaults();
    // reset values: one node, three iterations, d = 0.85
    send_command(CMD_READ, 0, 0, 0, 1);
    send_command(CMD_ADD, 0, 1, 0);
    send_command(CMD_ADD, 1, 1, 0);
    send_command(CMD_ADD, 0, 1, 1);
    send_command(CMD_RUN);
    send_command(CMD_READ, 0, 0, 0, 0);
  endtask

  task automatic test_directed();
    write_reg(REG_NODE_COUNT, 8);
    write_reg(REG_ITER_COUNT, 2);
    write_reg(REG_DAMPING, 65535);
    send_command(CMD_CLEAR);
    send_command(CMD_ADD, 0, 1, 7);
    send_command(CMD_ADD, 7, 1, 0);
    send_command(CMD_ADD, 4095, 0, 3);     // unknown source beyond range is fine
    send_command(CMD_ADD, 8, 1, 2);        // known source out of range
    send_command(CMD_ADD, 2, 1, 4095);     // target out of range
    send_command(CMD_ADD, 3, 1, 3);
    send_command(CMD_RUN);
    for (int q = 0; q < 8; q++) send_command(CMD_READ, 0, 0, 0, q);
    // shrink the node count: links touching node 7 drop out of the run
    write_reg(REG_NODE_COUNT, 4);
    write_reg(REG_DAMPING, 0);
    send_command(CMD_RUN);
    send_command(CMD_READ, 0, 0, 0, 0);
    send_command(CMD_READ, 0, 0, 0, 3);
    // clear keeps ranks but drops degrees
    send_command(CMD_CLEAR);
    send_command(CMD_READ, 0, 0, 0, 3);
    // zero node count acts as one node, zero iterations
    write_reg(REG_NODE_COUNT, 0);
    write_reg(REG_ITER_COUNT, 0);
    send_command(CMD_ADD, 0, 1, 0);
    send_command(CMD_RUN);
    send_command(CMD_READ, 0, 0, 0, 0);
    // most iterations on a tiny graph
    write_reg(REG_NODE_COUNT, 2);
    write_reg(REG_ITER_COUNT, 255);
    write_reg(REG_DAMPING, 55706);
    send_command(CMD_ADD, 1, 1, 0);
    send_command(CMD_RUN);
    send_command(CMD_READ, 0, 0, 0, 1);
    // node count above the table size acts as the full table
    write_reg(REG_NODE_COUNT, 8191);
    write_reg(REG_ITER_COUNT, 1);
    send_command(CMD_CLEAR);
    send_command(CMD_ADD, 4095, 1, 4095);
    send_command(CMD_ADD, 0, 1, 4095);
    send_command(CMD_RUN);
    send_command(CMD_READ, 0, 0, 0, 4095);
    write_reg(REG_NODE_COUNT, 4096);
    send_command(CMD_READ, 0, 0, 0, 2048);
  endtask

  task automatic test_store_full();
    write_reg(REG_NODE_COUNT, 2);
    send_command(CMD_CLEAR);
    for (int k = 0; k < LINKS; k++) send_command(CMD_ADD, k & 1, k[1], k[2], 0, 1'b0);
    send_command(CMD_ADD, 0, 1, 1);
    send_command(CMD_ADD, 0, 1, 4095);     // full wins over out of range
    send_command(CMD_READ, 0, 0, 0, 1);
    send_command(CMD_CLEAR);
  endtask

  task automatic test_backpressure();
    write_reg(REG_NODE_COUNT, 16);
    hold_cycles = 400;
    for (int i = 0; i < 12; i++) send_command(CMD_ADD, $urandom_range(15), 1, $urandom_range(15));
    drain_reports();
    send_command(CMD_READ, 0, 0, 0, $urandom_range(15));
  endtask

  task automatic test_random();
    int unsigned n;
    int unsigned p;
    int unsigned sent;
    stall_enable = 1'b1;
    sent = 0;
    while (sent < 800) begin
      p = $urandom_range(9);
      write_reg(REG_NODE_COUNT, (p == 0) ? $urandom_range(8191) :
                                (p < 3) ? $urandom_range(40, 17) : $urandom_range(16, 1));
      write_reg(REG_ITER_COUNT, ($urandom_range(9) == 0) ? 0 : $urandom_range(4, 1));
      p = $urandom_range(9);
      write_reg(REG_DAMPING, (p == 0) ? 0 : (p == 1) ? 65535 : $urandom_range(65535));
      n = active_nodes();
      if ($urandom_range(1)) send_command(CMD_CLEAR);
      repeat (90) begin
        p = $urandom_range(99);
        if (p < 45) begin
          if (link_cnt >= 24) send_command(CMD_CLEAR);
          else if ($urandom_range(9) == 0)
            send_command(CMD_ADD, $urandom_range(4095), $urandom_range(1),
                         $urandom_range(4095), $urandom_range(4095));
          else
            send_command(CMD_ADD, $urandom_range(n - 1), $urandom_range(3) != 0,
                         $urandom_range(n - 1), $urandom_range(4095));
        end else if (p < 53) begin
          if (n > 64) send_command(CMD_CLEAR);
          send_command(CMD_RUN, $urandom_range(4095), $urandom_range(1),
                       $urandom_range(4095), $urandom_range(4095));
        end else if (p < 56) begin
          send_command(CMD_CLEAR);
        end else begin
          send_command(CMD_READ, $urandom_range(4095), $urandom_range(1),
                       $urandom_range(4095), pick_query());
        end
        sent++;
        if ($urandom_range(39) == 0) drain_reports();
      end
    end
    stall_enable = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_NODE_COUNT;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_cmd = CMD_CLEAR;
    in_source_node = '0;
    in_source_known = 1'b0;
    in_target_node = '0;
    in_query_node = '0;
    node_cnt = NODE_COUNT_RST;
    iter_cnt = ITER_COUNT_RST;
    damping = DAMP_RST;
    link_cnt = 0;
    cur_bank = 1'b0;
    ranked_nodes = 0;
    mismatches = 0;
    hold_cycles = 0;
    stall_enable = 1'b0;
    for (int i = 0; i < NODES; i++) begin
      in_deg_tbl[i] = 0;
      out_deg_tbl[i] = 0;
      rank_bank[0][i] = '0;
      rank_bank[1][i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_defaults();
    test_directed();
    test_store_full();
    test_backpressure();
    test_random();

    drain_reports();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
